@@ src/htt_pkg.sv @@
// Package for the health tracking table.
// Holds the transfer payload types, the token that travels along the cell chain,
// and the command, health and status codes. It depends on nothing.
package htt_pkg;

    localparam logic [1:0] CMD_PROBE  = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_DRAIN  = 2'd2;
    localparam logic [1:0] CMD_FORGET = 2'd3;

    localparam logic [1:0] HEALTH_UNKNOWN   = 2'd0;
    localparam logic [1:0] HEALTH_HEALTHY   = 2'd1;
    localparam logic [1:0] HEALTH_UNHEALTHY = 2'd2;

    localparam logic [1:0] STATUS_DONE        = 2'd0;
    localparam logic [1:0] STATUS_FULL        = 2'd1;
    localparam logic [1:0] STATUS_NOT_TRACKED = 2'd2;

    localparam logic [7:0] FAILURES_MAX      = 8'hFF;
    localparam logic [7:0] THRESHOLD_DEFAULT = 8'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] kind_id;
        logic [15:0] container_id;
        logic        probe_ok;
        logic        drain_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       serviceable;
        logic [1:0] health;
        logic       is_drained;
        logic [7:0] failure_count;
        logic       drained_removed;
    } t_out_item;

    typedef struct packed {
        logic       vld;
        logic       make;
        t_in_item   item;
        logic       hit;
        logic [1:0] health;
        logic       drained;
        logic [7:0] failures;
        logic       removed;
    } t_tok;

endpackage

@@ src/htt_in_if.sv @@
// Input channel of the health tracking table: valid, ready and one command item.
// Depends on htt_pkg.
interface htt_in_if;
    import htt_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/htt_out_if.sv @@
// Result channel of the health tracking table: valid, ready and one result item.
// Depends on htt_pkg.
interface htt_out_if;
    import htt_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/htt_cfg_if.sv @@
// Configuration write channel of the health tracking table: valid, ready and
// the failure threshold. Depends on nothing.
interface htt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/htt_cell.sv @@
// One cell of the table chain: holds a single health record and passes the
// command token, updated, on to its neighbor in the next cycle. Depends on htt_pkg.
module htt_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_threshold,
    input  htt_pkg::t_tok i_tok,
    output htt_pkg::t_tok o_tok
);
    import htt_pkg::*;

    logic                r_valid;
    logic [KEY_BITS-1:0] r_kind;
    logic [KEY_BITS-1:0] r_cont;
    logic [1:0]          r_health;
    logic                r_drained;
    logic [7:0]          r_failures;
    t_tok                r_tok;

    logic                n_valid;
    logic [1:0]          n_health;
    logic                n_drained;
    logic [7:0]          n_failures;
    t_tok                n_tok;

    logic [KEY_BITS-1:0] key_kind;
    logic [KEY_BITS-1:0] key_cont;
    logic                match_cont;
    logic                match_key;
    logic                is_forget;
    logic                claim;
    logic                clear;
    logic [1:0]          base_health;
    logic                base_drained;
    logic [7:0]          base_failures;
    logic [7:0]          inc_failures;

    always_comb begin
        key_kind   = KEY_BITS'(i_tok.item.kind_id);
        key_cont   = KEY_BITS'(i_tok.item.container_id);
        match_cont = r_valid && (r_cont == key_cont);
        match_key  = match_cont && (r_kind == key_kind);
        is_forget  = (i_tok.item.cmd == CMD_FORGET);
        claim      = i_tok.vld && !i_tok.hit && !is_forget
                     && (i_tok.make ? !r_valid : match_key);
        clear      = i_tok.vld && !i_tok.make && is_forget && match_cont;

        base_health   = i_tok.make ? HEALTH_UNKNOWN : r_health;
        base_drained  = i_tok.make ? 1'b0 : r_drained;
        base_failures = i_tok.make ? 8'd0 : r_failures;
        inc_failures  = (base_failures == FAILURES_MAX) ? base_failures
                                                        : base_failures + 8'd1;

        n_health   = base_health;
        n_drained  = base_drained;
        n_failures = base_failures;
        unique case (i_tok.item.cmd)
            CMD_PROBE: begin
                if (i_tok.item.probe_ok) begin
                    n_health   = HEALTH_HEALTHY;
                    n_failures = 8'd0;
                end else begin
                    n_failures = inc_failures;
                    if (inc_failures >= i_threshold) begin
                        n_health = HEALTH_UNHEALTHY;
                    end
                end
            end
            CMD_DRAIN: begin
                n_drained = i_tok.item.drain_value;
            end
            default: begin
            end
        endcase

        n_valid = r_valid;
        if (clear) begin
            n_valid = 1'b0;
        end else if (claim) begin
            n_valid = 1'b1;
        end

        n_tok = i_tok;
        if (claim) begin
            n_tok.hit      = 1'b1;
            n_tok.health   = n_health;
            n_tok.drained  = n_drained;
            n_tok.failures = n_failures;
        end
        if (clear && r_drained) begin
            n_tok.removed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            r_kind     <= key_kind;
            r_cont     <= key_cont;
            r_health   <= n_health;
            r_drained  <= n_drained;
            r_failures <= n_failures;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ src/health_tracking_table.sv @@
// Health tracking table: TABLE_ENTRIES records in a chain of cells, one record
// per cell. An accepted command travels down the chain as a token, one cell per
// cycle; its result is registered at the end of the chain, and the next command
// can be taken once that result has moved on to the output register. A probe
// result or set-drain whose key is missing makes a second trip to claim the
// first free cell before its result is registered. One command is in the chain
// at a time; a finished result waits in an output register while the next
// command is taken, and a result that is not taken holds the one behind it and
// stops the input. The failure threshold is written through the configuration
// channel, which is ready whenever reset is released, and resets to 3.
// Depends on htt_pkg, htt_in_if, htt_out_if, htt_cfg_if and htt_cell.
module health_tracking_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    htt_cfg_if.sink     i_cfg,
    htt_in_if.sink      i_in,
    htt_out_if.source   o_out
);
    import htt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic      r_state;
    logic      n_state;
    logic [7:0] r_threshold;
    t_out_item r_res;
    logic      r_res_vld;
    t_out_item r_out;
    logic      r_out_vld;

    t_tok      w_tok [TABLE_ENTRIES+1];
    t_tok      tok_end;
    t_tok      inj;
    t_out_item res;
    logic      accept;
    logic      need_make;
    logic      finish;
    logic      move;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            htt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_threshold (r_threshold),
                .i_tok       (w_tok[gi]),
                .o_tok       (w_tok[gi+1])
            );
        end
    endgenerate

    assign w_tok[0]    = inj;
    assign tok_end     = w_tok[TABLE_ENTRIES];
    assign i_in.ready  = i_rst_n && (r_state == ST_IDLE) && !r_res_vld;
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = i_rst_n;

    always_comb begin
        need_make = tok_end.vld && !tok_end.make && !tok_end.hit
                    && ((tok_end.item.cmd == CMD_PROBE) || (tok_end.item.cmd == CMD_DRAIN));
        finish    = tok_end.vld && !need_make;

        inj = '0;
        if (accept) begin
            inj.vld  = 1'b1;
            inj.item = i_in.data;
        end else if (need_make) begin
            inj.vld  = 1'b1;
            inj.make = 1'b1;
            inj.item = tok_end.item;
        end

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        res                 = '0;
        res.status          = STATUS_DONE;
        res.serviceable     = 1'b1;
        if (tok_end.item.cmd == CMD_FORGET) begin
            res.drained_removed = tok_end.removed;
        end else if (tok_end.hit) begin
            res.serviceable   = !tok_end.drained && (tok_end.health != HEALTH_UNHEALTHY);
            res.health        = tok_end.health;
            res.is_drained    = tok_end.drained;
            res.failure_count = tok_end.failures;
        end else if (tok_end.item.cmd == CMD_QUERY) begin
            res.status = STATUS_NOT_TRACKED;
        end else begin
            res.status = STATUS_FULL;
        end

        move = r_res_vld && (!r_out_vld || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_threshold <= THRESHOLD_DEFAULT;
            r_res_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_threshold <= i_cfg.data;
            end
            if (finish) begin
                r_res_vld <= 1'b1;
            end else if (move) begin
                r_res_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_res <= res;
        end
        if (move) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule
